FILE: rtl/h2b_pkg.sv
// ============================================================================
// h2b_pkg
// Shared types, constants and the texel packing function of the bump-map block.
// ============================================================================
`default_nettype none

package h2b_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 4096;

    localparam int CFG_W    = 13;
    localparam int FMT_W    = 2;
    localparam int SAMPLE_W = 8;
    localparam int TEXEL_W  = 32;

    // Output queue depth: one entry on show, one draining, one for the beat in flight
    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FORMAT = 2'd2;

    // Texel packing codes
    localparam logic [FMT_W-1:0] FMT_U8V8     = 2'd0;
    localparam logic [FMT_W-1:0] FMT_L6V5U5   = 2'd1;
    localparam logic [FMT_W-1:0] FMT_X8L8V8U8 = 2'd2;

    localparam logic [SAMPLE_W-1:0] LIGHT_RAISED = 8'd63;
    localparam logic [SAMPLE_W-1:0] LIGHT_FLAT   = 8'd127;

    // Cross neighbourhood captured when a sample is taken
    typedef struct packed {
        logic [SAMPLE_W-1:0] centre;
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] up;
        logic [SAMPLE_W-1:0] down;
        logic                clamp_right;
        logic                last;
    } h2b_nbhd_t;

    function automatic logic [TEXEL_W-1:0] pack_texel(
        input logic signed [SAMPLE_W:0] du,
        input logic signed [SAMPLE_W:0] dv,
        input logic [SAMPLE_W-1:0]      light,
        input logic [FMT_W-1:0]         fmt
    );
        logic [TEXEL_W-1:0] t;
        begin
            case (fmt)
                FMT_U8V8:
                    t = {16'd0, dv[7:0], du[7:0]};
                FMT_L6V5U5:
                    t = {16'd0, light[7:2], dv[7:3], du[7:3]};
                FMT_X8L8V8U8:
                    t = {8'd0, light, dv[7:0], du[7:0]};
                default:
                    t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/h2b_line_store.sv
// ============================================================================
// h2b_line_store
// Two line stores (previous row, centre row) sharing one address port pair,
// read data registered, write-to-read forwarding on the same entry.
// ============================================================================
`default_nettype none

module h2b_line_store
    import h2b_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_WIDTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  wire logic [SAMPLE_W-1:0]          wr_centre,
    input  wire logic [SAMPLE_W-1:0]          wr_prev,
    output logic      [SAMPLE_W-1:0]          rd_centre,
    output logic      [SAMPLE_W-1:0]          rd_prev
);

    logic [SAMPLE_W-1:0] centre_mem [DEPTH];
    logic [SAMPLE_W-1:0] prev_mem   [DEPTH];
    logic [SAMPLE_W-1:0] rd_centre_reg;
    logic [SAMPLE_W-1:0] rd_prev_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            centre_mem[wr_addr] <= wr_centre;
            prev_mem[wr_addr]   <= wr_prev;
        end
        if (rd_en)
        begin
            // forward the write when both ports hit the same entry
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_centre_reg <= wr_centre;
                rd_prev_reg   <= wr_prev;
            end
            else
            begin
                rd_centre_reg <= centre_mem[rd_addr];
                rd_prev_reg   <= prev_mem[rd_addr];
            end
        end
    end

    assign rd_centre = rd_centre_reg;
    assign rd_prev   = rd_prev_reg;

endmodule

`default_nettype wire

FILE: rtl/h2b_gradient.sv
// ============================================================================
// h2b_gradient
// Gradient and light value of one pixel, packed into a texel.
// ============================================================================
`default_nettype none

module h2b_gradient
    import h2b_pkg::*;
(
    input  wire h2b_nbhd_t                nbhd,
    input  wire logic [SAMPLE_W-1:0]      right_sample,
    input  wire logic [FMT_W-1:0]         fmt,
    output logic      [TEXEL_W-1:0]       texel
);

    logic [SAMPLE_W-1:0]      right;
    logic signed [SAMPLE_W:0] du_plain;
    logic signed [SAMPLE_W:0] du_left;
    logic signed [SAMPLE_W:0] du_right;
    logic signed [SAMPLE_W:0] du;
    logic signed [SAMPLE_W:0] dv;
    logic                     valley;
    logic [SAMPLE_W-1:0]      light;

    always_comb
    begin
        right    = nbhd.clamp_right ? nbhd.centre : right_sample;
        du_plain = $signed({1'b0, nbhd.left} - {1'b0, right});
        du_left  = $signed({1'b0, nbhd.left} - {1'b0, nbhd.centre});
        du_right = $signed({1'b0, nbhd.centre} - {1'b0, right});
        valley   = (nbhd.centre < nbhd.left) && (nbhd.centre < right);
        // at a valley take the greater of the two signed one-sided slopes
        if (valley)
        begin
            du = (du_left < du_right) ? du_right : du_left;
        end
        else
        begin
            du = du_plain;
        end
        dv    = $signed({1'b0, nbhd.down} - {1'b0, nbhd.up});
        light = (nbhd.centre > 8'd1) ? LIGHT_RAISED : LIGHT_FLAT;
        texel = pack_texel(du, dv, light, fmt);
    end

endmodule

`default_nettype wire

FILE: rtl/h2b_out_queue.sv
// ============================================================================
// h2b_out_queue
// Small output queue that parts the compute stage from the result channel.
// ============================================================================
`default_nettype none

module h2b_out_queue
    import h2b_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire logic [TEXEL_W-1:0]    push_texel,
    input  wire logic                  push_last,
    input  wire logic                  take,
    output logic      [OUTQ_CW-1:0]    count,
    output logic                       valid,
    output logic      [TEXEL_W-1:0]    texel,
    output logic                       last
);

    logic [TEXEL_W-1:0] texel_mem [OUTQ_DEPTH];
    logic               last_mem  [OUTQ_DEPTH];
    logic [OUTQ_PW-1:0] head_reg;
    logic [OUTQ_PW-1:0] head_next;
    logic [OUTQ_PW-1:0] tail_reg;
    logic [OUTQ_PW-1:0] tail_next;
    logic [OUTQ_CW-1:0] count_reg;
    logic [OUTQ_CW-1:0] count_next;
    logic               pop;

    assign valid = (count_reg != '0);
    assign pop   = valid && take;
    assign count = count_reg;
    assign texel = texel_mem[head_reg];
    assign last  = last_mem[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (pop)
        begin
            head_next = (head_reg == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == OUTQ_PW'(OUTQ_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            texel_mem[tail_reg] <= push_texel;
            last_mem[tail_reg]  <= push_last;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/height_to_bump_map.sv
// ============================================================================
// height_to_bump_map
// Streaming bump-map generator: height samples in, packed bump texels out.
// ============================================================================
// Usage:
//   s_* channel: one 8-bit height sample per beat, raster order.
//   m_* channel: one packed texel per beat, raster order; m_tlast marks the
//   last column of a frame's last row.
//   APB port: image_width (0x0), image_height (0x4), bump_format (0x8).
//   Write configuration only while the block is idle.
// Order: the texel of row r, column x leaves with sample x of row r+1.
//   It is registered in s1, then queued, before it shows on m_tvalid. The first row
//   after reset gives no texels; a frame's last row leaves while the next
//   frame's first row streams in.
// Throughput: one beat per cycle on both sides while m_tready stays high. The
//   line store has one read port; it reads the next column ahead while a sample
//   is taken, so the centre, the one above and the right neighbour are at hand
//   each cycle. After reset, or a size change that moves the current column,
//   that column is re-read first (s_tready low for a single cycle).
// Reset: counters, row flags and the output queue clear; line stores keep
//   whatever they hold. When the receiver stalls, the three-entry queue fills
//   and s_tready drops; nothing is lost.
// ============================================================================
`default_nettype none

module height_to_bump_map
    import h2b_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input samples
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] height_sample
    // output texels
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [31:0]          m_tdata,   // [31:0] texel
    output logic                      m_tlast,   // last_in_frame
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    localparam int AW = $clog2(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [FMT_W-1:0] format_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            format_reg <= FMT_U8V8;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_FORMAT: format_reg <= pwdata[FMT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_FORMAT: prdata = 32'(format_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------
    logic [AW-1:0]    col_reg;
    logic [CFG_W-1:0] row_reg;
    logic             pend_valid_reg;
    logic             pend_first_reg;
    logic             pend_last_reg;
    logic [AW-1:0]    w_last;
    logic [CFG_W-1:0] h_last;
    logic [AW-1:0]    x;
    logic [AW-1:0]    next_col;
    logic             at_row_end;
    logic             frame_end;

    always_comb
    begin
        // width 0 acts as 1, above the line store acts as its depth
        if (width_reg == '0)
        begin
            w_last = '0;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_last = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            w_last = AW'(width_reg - 1'b1);
        end
        h_last     = (height_reg == '0) ? '0 : height_reg - 1'b1;
        x          = (col_reg > w_last) ? w_last : col_reg;
        at_row_end = (x == w_last);
        next_col   = at_row_end ? '0 : x + 1'b1;
        frame_end  = (row_reg >= h_last);
    end

    // ------------------------------------------------------------------
    // Line store with read-ahead of the next column
    // ------------------------------------------------------------------
    logic                accept;
    logic                pf_valid_reg;
    logic [AW-1:0]       pf_addr_reg;
    logic                pf_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [SAMPLE_W-1:0] rd_centre;
    logic [SAMPLE_W-1:0] rd_prev;
    logic [OUTQ_CW-1:0]  q_count;
    logic                s1_valid_reg;

    // the read-ahead data is usable only if it was fetched for this column
    assign pf_ok    = pf_valid_reg && (pf_addr_reg == x);
    assign s_tready = pf_ok && ((32'(q_count) + 32'(s1_valid_reg)) < OUTQ_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept || !pf_ok;
    assign rd_addr  = accept ? next_col : x;

    h2b_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (accept),
        .wr_addr   (x),
        .wr_centre (s_tdata),
        .wr_prev   (rd_centre),
        .rd_centre (rd_centre),
        .rd_prev   (rd_prev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_valid_reg <= 1'b0;
            pf_addr_reg  <= '0;
        end
        else if (rd_en)
        begin
            pf_valid_reg <= 1'b1;
            pf_addr_reg  <= rd_addr;
        end
    end

    // ------------------------------------------------------------------
    // Sample beat: capture the neighbourhood, advance the counters
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] left_reg;
    h2b_nbhd_t           nbhd;
    h2b_nbhd_t           s1_reg;

    always_comb
    begin
        nbhd.centre      = rd_centre;
        nbhd.left        = (x == '0) ? rd_centre : left_reg;
        nbhd.up          = pend_first_reg ? rd_centre : rd_prev;
        nbhd.down        = pend_last_reg ? rd_centre : s_tdata;
        nbhd.clamp_right = at_row_end;
        nbhd.last        = pend_last_reg && at_row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_first_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            left_reg       <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && pend_valid_reg;
            if (accept)
            begin
                col_reg  <= next_col;
                left_reg <= rd_centre;
                if (at_row_end)
                begin
                    // the row just stored becomes the one to emit
                    pend_valid_reg <= 1'b1;
                    pend_first_reg <= (row_reg == '0);
                    pend_last_reg  <= frame_end;
                    row_reg        <= frame_end ? '0 : row_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= nbhd;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage: right neighbour arrives from the read-ahead
    // ------------------------------------------------------------------
    logic [TEXEL_W-1:0] texel;

    h2b_gradient u_grad (
        .nbhd         (s1_reg),
        .right_sample (rd_centre),
        .fmt          (format_reg),
        .texel        (texel)
    );

    h2b_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_valid_reg),
        .push_texel (texel),
        .push_last  (s1_reg.last),
        .take       (m_tready),
        .count      (q_count),
        .valid      (m_tvalid),
        .texel      (m_tdata),
        .last       (m_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/h2b_checker.sv
// ============================================================================
// h2b_checker
// Port-level checks of the bump-map block, bound to its top level.
// ============================================================================
`default_nettype none

module h2b_checker
    import h2b_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        psel,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] prdata
);

    // a stalled texel beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("texel beat changed while stalled");

    // no packing uses the top byte
    a_top_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:24] == 8'd0))
        else $error("texel top byte not zero");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("texel beat right after reset");

    // register reads stay within the register widths
    a_read_width: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && ((paddr[3:2] == REG_WIDTH) || (paddr[3:2] == REG_HEIGHT))
        |-> (prdata[31:CFG_W] == '0))
        else $error("size register read has upper bits set");

    a_read_format: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[3:2] == REG_FORMAT) |-> (prdata[31:FMT_W] == '0))
        else $error("format register read has upper bits set");

endmodule

bind height_to_bump_map h2b_checker u_h2b_checker (.*);

`default_nettype wire

FILE: bench/height_to_bump_map_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// height_to_bump_map_tb
// Self-checking bench for the streaming bump-map block: height samples go in
// over the slave stream, every accepted beat is run through a texel predictor,
// and each texel beat on the master stream is checked against the oldest
// prediction. Sizes and packing formats are set over APB between phases.
// ============================================================================

module height_to_bump_map_tb
    import h2b_pkg::*;
;

    // Packing code with no named format: the texel field reads as zero
    localparam logic [FMT_W-1:0] FMT_NONE = 2'd3;

    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_TIME  = 8;      // cycles after the last texel before an APB write
    localparam int DRAIN_LIMIT  = 5_000;
    localparam int FILL_WIDTH   = 16;     // widest row used; written first so every read hits data
    localparam int HOLD_AFTER   = 8;      // texel count that starts the long receiver hold
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_BEATS = 64;
    localparam int REPORT_CAP   = 100;

    typedef enum {MIX_ANY, MIX_EDGES, MIX_RIDGES} height_mix_t;

    // ------------------------------------------------------------------------
    // Texel tracker: predicts texels from accepted heights and checks them
    // ------------------------------------------------------------------------
    class texel_tracker;
        typedef struct {
            logic [TEXEL_W-1:0] texel;
            logic               last;
        } texel_due_t;

        logic [CFG_W-1:0]    width_reg;
        logic [CFG_W-1:0]    height_reg;
        logic [FMT_W-1:0]    format_reg;
        logic [SAMPLE_W-1:0] row_above  [MAX_WIDTH_DEF];
        logic [SAMPLE_W-1:0] row_centre [MAX_WIDTH_DEF];
        logic [SAMPLE_W-1:0] left_of_column;
        int unsigned         column;
        int unsigned         row;
        bit                  row_waiting;
        bit                  waiting_first;
        bit                  waiting_last;
        texel_due_t          texels_due [$];
        int                  errors;

        function new();
            width_reg      = 1;
            height_reg     = 1;
            format_reg     = FMT_U8V8;
            left_of_column = '0;
            column         = 0;
            row            = 0;
            row_waiting    = 0;
            waiting_first  = 0;
            waiting_last   = 0;
            errors         = 0;
            foreach (row_above[i])
            begin
                row_above[i]  = '0;
                row_centre[i] = '0;
            end
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_WIDTH:  width_reg  = value[CFG_W-1:0];
                REG_HEIGHT: height_reg = value[CFG_W-1:0];
                REG_FORMAT: format_reg = value[FMT_W-1:0];
                default:    ;
            endcase
        endfunction

        task report(string msg);
            if (errors < REPORT_CAP)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // One height beat: emit the texel of the waiting row at this column,
        // then shift the column down through the line stores.
        function void take_height(logic [SAMPLE_W-1:0] height);
            int unsigned         w;
            int unsigned         h;
            int unsigned         x;
            int                  c;
            int                  lft;
            int                  rgt;
            int                  up;
            int                  dn;
            int                  du;
            int                  dv;
            logic [8:0]          du9;
            logic [8:0]          dv9;
            logic [SAMPLE_W-1:0] light;
            texel_due_t          due;

            w = (width_reg == 0) ? 1 :
                ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            x = (column >= w) ? w - 1 : column;
            c = row_centre[x];

            if (row_waiting)
            begin
                lft = (x == 0) ? c : int'(left_of_column);
                rgt = (x + 1 < w) ? int'(row_centre[x + 1]) : c;
                up  = waiting_first ? c : int'(row_above[x]);
                dn  = waiting_last ? c : int'(height);
                du  = lft - rgt;
                dv  = dn - up;
                // valley: take the greater of the two signed one-sided slopes
                if (c < lft && c < rgt)
                begin
                    du = lft - c;
                    if (du < c - rgt)
                        du = c - rgt;
                end
                light = (c > 1) ? LIGHT_RAISED : LIGHT_FLAT;
                du9   = du[8:0];
                dv9   = dv[8:0];
                case (format_reg)
                    FMT_U8V8:     due.texel = {16'd0, dv9[7:0], du9[7:0]};
                    FMT_L6V5U5:   due.texel = {16'd0, light[7:2], dv9[7:3], du9[7:3]};
                    FMT_X8L8V8U8: due.texel = {8'd0, light, dv9[7:0], du9[7:0]};
                    default:      due.texel = '0;
                endcase
                due.last = waiting_last && (x == w - 1);
                texels_due.push_back(due);
            end

            row_above[x]   = c[SAMPLE_W-1:0];
            row_centre[x]  = height;
            left_of_column = c[SAMPLE_W-1:0];

            if (x + 1 >= w)
            begin
                column        = 0;
                row_waiting   = 1;
                waiting_first = (row == 0);
                waiting_last  = (row + 1 >= h);
                row           = waiting_last ? 0 : row + 1;
            end
            else
                column = x + 1;
        endfunction

        task check_texel(logic [TEXEL_W-1:0] texel, logic last);
            texel_due_t due;
            if (texels_due.size() == 0)
            begin
                report($sformatf("texel %h arrived with none outstanding", texel));
                return;
            end
            due = texels_due.pop_front();
            if (texel !== due.texel)
                report($sformatf("texel %h, predicted %h", texel, due.texel));
            if (last !== due.last)
                report($sformatf("last flag %b, predicted %b (texel %h)", last, due.last,
                                 texel));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block
    // ------------------------------------------------------------------------
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    texel_tracker tracker = new();

    bit sender_steady   = 1'b0;   // no gaps between sample beats this phase
    bit receiver_steady = 1'b0;   // no stalls on the texel side this phase
    int cycle_count     = 0;
    int texels_taken    = 0;
    int hold_left       = 0;
    int stall_left      = 0;
    int random_beats    = 0;

    byte unsigned cross_pattern [16] = '{0, 255, 0, 255,  200, 10, 200, 1,
                                         2, 1, 2, 128,    255, 255, 0, 0};

    always #1 clk = ~clk;

    height_to_bump_map i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_height(height_mix_t mix);
        int r;
        r = $urandom_range(0, 6);
        case (mix)
            // near the ends of the range: light threshold and wrap of du/dv
            MIX_EDGES:
                return (r < 4) ? 8'(r) : 8'(255 - (r - 4));
            // high plateau with sharp pits, so valleys show up often
            MIX_RIDGES:
                return (r < 2) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(100, 255));
            default:
                return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Texel side: check each beat, stall at random, and hold off once for a
    // long stretch so the output queue fills and the sample side backs up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tracker.check_texel(m_tdata, m_tlast);
                texels_taken++;
                if (texels_taken == HOLD_AFTER)
                    hold_left = HOLD_CYCLES;
                else
                    stall_left = pick_gap(receiver_steady);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("height_to_bump_map: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that sees psel, penable and pready high together.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_register(idx, value);
    endtask

    // Write all three registers and pick how bursty both sides run this phase
    task automatic start_phase(input logic [12:0] w, input logic [12:0] h,
                               input logic [1:0] fmt);
        write_reg(REG_WIDTH, 32'(w));
        write_reg(REG_HEIGHT, 32'(h));
        write_reg(REG_FORMAT, 32'(fmt));
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
    endtask

    // Offer one height beat after a random gap; hold it until the block takes it.
    // Called at a rising edge; returns at the edge that accepted the beat.
    task automatic send_height(input logic [7:0] height);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= height;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        tracker.take_height(height);
    endtask

    // Drop valid, let every predicted texel arrive, then give the block a few
    // more cycles: a beat that emits nothing may still be in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.texels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);
    endtask

    task automatic send_rows(input int beats, input height_mix_t mix);
        for (int i = 0; i < beats; i++)
            send_height(pick_height(mix));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [12:0] w;
        logic [12:0] h;
        int          w_eff;
        int          rows;
        height_mix_t mix;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening row at the widest size used here, zero height and the
        // unnamed format. Nothing is pending yet, so no texels; this also
        // writes every line-store entry that later phases read.
        start_phase(13'(FILL_WIDTH), 13'd0, FMT_NONE);
        send_rows(FILL_WIDTH, MIX_ANY);
        settle();

        // Same width; emits the row above with both vertical clamps.
        // The long receiver hold lands in here.
        start_phase(13'(FILL_WIDTH), 13'd1, FMT_X8L8V8U8);
        send_rows(FILL_WIDTH, MIX_RIDGES);
        settle();

        // Two small frames: extremes, valleys, light threshold around 1
        start_phase(13'd4, 13'd2, FMT_U8V8);
        foreach (cross_pattern[i])
            send_height(8'(cross_pattern[i]));
        settle();

        // One-pixel rows: both horizontal neighbours clamp to the centre
        start_phase(13'd1, 13'd8191, FMT_L6V5U5);
        send_height(8'd255);
        send_height(8'd0);
        send_height(8'd1);
        send_height(8'd254);
        settle();

        // Zero width acts as one; height shrinks below the current row count
        start_phase(13'd0, 13'd2, FMT_NONE);
        send_height(8'd2);
        send_height(8'd255);
        send_height(8'd0);

        // Random phases: small sizes, every format, whole rows per phase
        while (random_beats < RANDOM_BEATS)
        begin
            settle();
            w = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 10));
            h = ($urandom_range(0, 9) == 0) ? 13'd8191 : 13'($urandom_range(0, 4));
            start_phase(w, h, 2'($urandom_range(0, 3)));
            w_eff = (w == 0) ? 1 : int'(w);
            rows  = $urandom_range(1, 3);
            mix   = height_mix_t'($urandom_range(0, 2));
            send_rows(w_eff * rows, mix);
            random_beats += w_eff * rows;
        end

        // Drain with a bound, then leave room for any stray beat
        s_tvalid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && tracker.texels_due.size() != 0; n++)
            @(posedge clk);
        repeat (4 * SETTLE_TIME) @(posedge clk);
        if (tracker.texels_due.size() != 0)
            tracker.report($sformatf("%0d predicted texels never arrived",
                                     tracker.texels_due.size()));

        if (tracker.errors == 0)
            $display("height_to_bump_map: match");
        else
            $display("height_to_bump_map: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/h2b_pkg.sv
rtl/h2b_line_store.sv
rtl/h2b_gradient.sv
rtl/h2b_out_queue.sv
rtl/height_to_bump_map.sv
rtl/h2b_checker.sv
bench/height_to_bump_map_tb.sv
